FILE: design/tt_pkg.sv
// Shared types, codes and constants of the transposition table.
`default_nettype none

package tt_pkg;

	localparam int unsigned KEY_W   = 64;
	localparam int unsigned MOVE_W  = 8;
	localparam int unsigned SCORE_W = 16;
	localparam int unsigned DEPTH_W = 8;
	localparam int unsigned FLAG_W  = 2;
	localparam int unsigned PLY_W   = 8;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned THR_W   = 15;

	localparam int unsigned S_TDATA_W  = 144;
	localparam int unsigned M_TDATA_W  = 32;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	// Key bits folded into the index remainder per cycle when the table
	// size is not a power of two.
	localparam int unsigned MOD_BITS  = 4;
	localparam int unsigned MOD_STEPS = KEY_W / MOD_BITS;

	localparam logic [OP_W-1:0] OP_PROBE = 2'd0;
	localparam logic [OP_W-1:0] OP_STORE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [FLAG_W-1:0] FLAG_NONE  = 2'd0;
	localparam logic [FLAG_W-1:0] FLAG_UPPER = 2'd1;
	localparam logic [FLAG_W-1:0] FLAG_LOWER = 2'd2;
	localparam logic [FLAG_W-1:0] FLAG_EXACT = 2'd3;

	localparam logic [MOVE_W-1:0] NO_MOVE = 8'hFF;

	localparam logic           CFG_MATE_THR   = 1'b0;
	localparam logic [THR_W-1:0] MATE_THR_RESET = 15'd30000;

	// Input item, key in the lowest bits.
	typedef struct packed {
		logic [PLY_W-1:0]          ply;
		logic [FLAG_W-1:0]         bound_flag;
		logic [DEPTH_W-1:0]        depth;
		logic signed [SCORE_W-1:0] beta;
		logic signed [SCORE_W-1:0] alpha;
		logic signed [SCORE_W-1:0] score;
		logic [MOVE_W-1:0]         move;
		logic [KEY_W-1:0]          key;
	} item_t;

	localparam int unsigned ITEM_W = $bits(item_t);

	// Result item, key_match in the lowest bit.
	typedef struct packed {
		logic signed [SCORE_W-1:0] score_out;
		logic                      cutoff;
		logic [MOVE_W-1:0]         move_out;
		logic                      key_match;
	} res_t;

	localparam int unsigned RES_W = $bits(res_t);

	typedef struct packed {
		logic [KEY_W-1:0]          key;
		logic [MOVE_W-1:0]         move;
		logic signed [SCORE_W-1:0] score;
		logic [DEPTH_W-1:0]        depth;
		logic [FLAG_W-1:0]         flag;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		key:   '0,
		move:  NO_MOVE,
		score: '0,
		depth: '0,
		flag:  FLAG_NONE
	};

	typedef struct packed {
		logic load;
		logic mod_step;
		logic mem_rd;
		logic mem_wr;
		logic clr_wr;
		logic check;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic            idx_ready;
		logic            clr_last;
		logic [OP_W-1:0] op;
	} stat_t;

endpackage

`default_nettype wire

FILE: design/tt_dpath.sv
// Datapath of the transposition table: entry memory, index, score logic.
`default_nettype none

module tt_dpath #(
	parameter int unsigned TABLE_ENTRIES = 65536
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tt_pkg::cmd_t                 cmd,
	output tt_pkg::stat_t                     stat,
	input  wire tt_pkg::item_t                item_in,
	input  wire logic [tt_pkg::OP_W-1:0]      op_in,
	input  wire logic [tt_pkg::THR_W-1:0]     mate_thr,
	output tt_pkg::res_t                      res
);

	localparam int unsigned IW   = $clog2(TABLE_ENTRIES);
	localparam bit          POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	tt_pkg::item_t             item_q;
	logic [tt_pkg::OP_W-1:0]   op_q;
	logic [IW-1:0]             idx;
	logic                      idx_ready;
	logic [IW-1:0]             clr_cnt_q;

	tt_pkg::entry_t            mem [TABLE_ENTRIES];
	tt_pkg::entry_t            rdata_q;
	tt_pkg::entry_t            wdata;
	logic [IW-1:0]             waddr;
	logic                      we;

	logic                              match_q;
	logic                              deep_q;
	logic signed [tt_pkg::SCORE_W-1:0] sadj_q;
	logic [tt_pkg::FLAG_W-1:0]         eflag_q;
	logic [tt_pkg::MOVE_W-1:0]         emove_q;
	tt_pkg::res_t                      res_nx;
	tt_pkg::res_t                      res_q;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			return 16'sh8000;
		end
		return $signed(v[15:0]);
	endfunction

	// Mate scores move away from zero by ply on a store and back on a probe.
	function automatic logic signed [15:0] mate_adj(
		input logic signed [15:0] s,
		input logic [14:0]        thr,
		input logic [7:0]         ply,
		input logic               to_root
	);
		logic signed [17:0] sx;
		logic signed [17:0] tx;
		logic signed [17:0] px;
		logic signed [17:0] v;
		sx = 18'(s);
		tx = $signed({3'b000, thr});
		px = $signed({10'b0, ply});
		if (sx > tx) begin
			v = to_root ? sx - px : sx + px;
		end else if (sx < -tx) begin
			v = to_root ? sx + px : sx - px;
		end else begin
			v = sx;
		end
		return sat16(v);
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item_in;
			op_q   <= op_in;
		end
	end

	generate
		if (POW2) begin : g_mask
			assign idx       = item_q.key[IW-1:0];
			assign idx_ready = 1'b1;
		end else begin : g_mod
			localparam logic [IW:0] NW = (IW + 1)'(TABLE_ENTRIES);
			localparam int unsigned CW = $clog2(tt_pkg::MOD_STEPS + 1);

			logic [IW-1:0]            rem_q;
			logic [IW-1:0]            rem_nx;
			logic [tt_pkg::KEY_W-1:0] ksh_q;
			logic [CW-1:0]            mcnt_q;

			// Long division of the key by the table size, a few bits a cycle.
			always_comb begin
				logic [IW:0]   t;
				logic [IW-1:0] r;
				r = rem_q;
				for (int j = 0; j < int'(tt_pkg::MOD_BITS); j++) begin
					t = {r, ksh_q[tt_pkg::KEY_W-1-j]};
					if (t >= NW) begin
						t = t - NW;
					end
					r = t[IW-1:0];
				end
				rem_nx = r;
			end

			always_ff @(posedge clk) begin
				if (cmd.load) begin
					rem_q <= '0;
					ksh_q <= item_in.key;
				end else if (cmd.mod_step) begin
					rem_q <= rem_nx;
					ksh_q <= ksh_q << tt_pkg::MOD_BITS;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					mcnt_q <= '0;
				end else if (cmd.load) begin
					mcnt_q <= '0;
				end else if (cmd.mod_step) begin
					mcnt_q <= mcnt_q + 1'b1;
				end
			end

			assign idx       = rem_q;
			assign idx_ready = mcnt_q == CW'(tt_pkg::MOD_STEPS);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= (clr_cnt_q == LAST_IDX) ? '0 : clr_cnt_q + 1'b1;
		end
	end

	always_comb begin
		we    = cmd.mem_wr || cmd.clr_wr;
		waddr = cmd.clr_wr ? clr_cnt_q : idx;
		if (cmd.clr_wr) begin
			wdata = tt_pkg::ENTRY_RESET;
		end else begin
			wdata.key   = item_q.key;
			wdata.move  = item_q.move;
			wdata.score = mate_adj(item_q.score, mate_thr, item_q.ply, 1'b0);
			wdata.depth = item_q.depth;
			wdata.flag  = item_q.bound_flag;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rdata_q <= mem[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			match_q <= rdata_q.key == item_q.key;
			deep_q  <= rdata_q.depth >= item_q.depth;
			sadj_q  <= mate_adj(rdata_q.score, mate_thr, item_q.ply, 1'b1);
			eflag_q <= rdata_q.flag;
			emove_q <= rdata_q.move;
		end
	end

	always_comb begin
		res_nx.key_match = 1'b0;
		res_nx.move_out  = tt_pkg::NO_MOVE;
		res_nx.cutoff    = 1'b0;
		res_nx.score_out = '0;
		if (op_q == tt_pkg::OP_PROBE && match_q) begin
			res_nx.key_match = 1'b1;
			res_nx.move_out  = emove_q;
			if (deep_q) begin
				res_nx.score_out = sadj_q;
				case (eflag_q)
					tt_pkg::FLAG_UPPER: begin
						if (sadj_q <= item_q.alpha) begin
							res_nx.cutoff    = 1'b1;
							res_nx.score_out = item_q.alpha;
						end
					end
					tt_pkg::FLAG_LOWER: begin
						if (sadj_q >= item_q.beta) begin
							res_nx.cutoff    = 1'b1;
							res_nx.score_out = item_q.beta;
						end
					end
					tt_pkg::FLAG_EXACT: begin
						res_nx.cutoff = 1'b1;
					end
					default: begin
						res_nx.cutoff = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q <= res_nx;
		end
	end

	assign res            = res_q;
	assign stat.idx_ready = idx_ready;
	assign stat.clr_last  = clr_cnt_q == LAST_IDX;
	assign stat.op        = op_q;

endmodule

`default_nettype wire

FILE: design/tt_ctrl.sv
// Sequencer of the transposition table: handshakes, clear sweep, op steps.
`default_nettype none

module tt_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_valid,
	input  wire logic [tt_pkg::OP_W-1:0] s_op,
	output logic                         s_ready,
	output logic                         m_valid,
	input  wire logic                    m_ready,
	input  wire tt_pkg::stat_t           stat,
	output tt_pkg::cmd_t                 cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INDEX,
		ST_CHECK,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   clr_item_q;
	logic   m_valid_q;
	logic   accept;
	logic   out_free;

	assign s_ready  = state_q == ST_IDLE;
	assign accept   = s_valid && s_ready;
	assign out_free = !m_valid_q || m_ready;
	assign m_valid  = m_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.load = accept;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			ST_IDLE: begin
				cmd.load = accept;
			end
			ST_INDEX: begin
				if (stat.idx_ready) begin
					if (stat.op == tt_pkg::OP_PROBE) begin
						cmd.mem_rd = 1'b1;
					end else begin
						cmd.mem_wr = 1'b1;
					end
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
			end
			ST_RESULT: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Reset starts in the clear sweep so the table reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_item_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (stat.clr_last) begin
						state_q    <= clr_item_q ? ST_RESULT : ST_IDLE;
						clr_item_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (s_op) inside
							tt_pkg::OP_PROBE, tt_pkg::OP_STORE: begin
								state_q <= ST_INDEX;
							end
							tt_pkg::OP_CLEAR: begin
								state_q    <= ST_CLEAR;
								clr_item_q <= 1'b1;
							end
							default: begin
								state_q <= ST_RESULT;
							end
						endcase
					end
				end
				ST_INDEX: begin
					if (stat.idx_ready) begin
						state_q <= (stat.op == tt_pkg::OP_PROBE) ? ST_CHECK : ST_RESULT;
					end
				end
				ST_CHECK: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_mem_port_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mem_rd, cmd.mem_wr, cmd.clr_wr}))
		else $error("entry memory driven by more than one access in a cycle");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result register overwritten while its item waits");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_ready)
		else $error("new item taken while the previous one is in progress");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_RESULT))
		else $error("result item raised outside the result step");
`endif

endmodule

`default_nettype wire

FILE: design/transposition_table.sv
// Top level of the transposition table: stream ports, register port, units.
//
// Direct-mapped, always-replace search cache of TABLE_ENTRIES entries held in a
// single-port memory and run by a sequencer, one item at a time. With a
// power-of-two table a probe steps from acceptance through index and memory
// read, entry check and result before the next acceptance, a store through
// index and memory write and result, and an unused op through result alone.
// Any other table size adds an index remainder step to each probe or store,
// folded from the key four bits a cycle. A clear writes one entry a cycle;
// after reset the same sweep runs before the first item is taken, while
// register writes are accepted as usual. A finished result sits in an output
// register, so the next item is accepted while it waits.
`default_nettype none

module transposition_table #(
	parameter int unsigned TABLE_ENTRIES = 65536
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// key, move, score, alpha, beta, depth, bound_flag, ply, zero pad
	input  wire logic [tt_pkg::S_TDATA_W-1:0]      s_tdata,
	// op
	input  wire logic [tt_pkg::OP_W-1:0]           s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// key_match, move_out, cutoff, score_out, zero pad
	output logic [tt_pkg::M_TDATA_W-1:0]           m_tdata,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [tt_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [tt_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [tt_pkg::APB_DATA_W-1:0]          prdata,
	output logic                                   pready
);

	tt_pkg::cmd_t               cmd;
	tt_pkg::stat_t              stat;
	tt_pkg::item_t              item;
	tt_pkg::res_t               res;
	logic [tt_pkg::THR_W-1:0]   mate_thr_q;
	logic                       cfg_wr;

	assign item   = tt_pkg::item_t'(s_tdata[tt_pkg::ITEM_W-1:0]);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Register index is the word address; the byte offset is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mate_thr_q <= tt_pkg::MATE_THR_RESET;
		end else if (cfg_wr && paddr[2] == tt_pkg::CFG_MATE_THR) begin
			mate_thr_q <= pwdata[tt_pkg::THR_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == tt_pkg::CFG_MATE_THR) begin
			prdata = {{(tt_pkg::APB_DATA_W - tt_pkg::THR_W){1'b0}}, mate_thr_q};
		end else begin
			prdata = '0;
		end
	end

	tt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_op    (s_tuser),
		.s_ready (s_tready),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	tt_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.item_in  (item),
		.op_in    (s_tuser),
		.mate_thr (mate_thr_q),
		.res      (res)
	);

	assign m_tdata = {{(tt_pkg::M_TDATA_W - tt_pkg::RES_W){1'b0}}, res};

endmodule

`default_nettype wire
